// ===== sv/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Shared codes and constants for the linear-probing hash table core.
// ----------------------------------------------------------------------------
package lph_pkg;

  // Command codes carried on the input tuser.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NEXT   = 2'd3;

  // Result status codes carried on the output tuser.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // djb2 hash constants.
  localparam logic [31:0] HASH_START = 32'd5381;
  localparam int unsigned HASH_SHIFT = 5;

  // Fixed field widths of the stream payloads.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 9;
  localparam int unsigned IN_W     = 104;
  localparam int unsigned OUT_W    = 120;

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_HASH     = 13'b0000000000010,
    S_INS      = 13'b0000000000100,
    S_LK_PROBE = 13'b0000000001000,
    S_LK_CMP   = 13'b0000000010000,
    S_RM_LOAD  = 13'b0000000100000,
    S_RM_SAVE  = 13'b0000001000000,
    S_RM_STEP  = 13'b0000010000000,
    S_RM_FETCH = 13'b0000100000000,
    S_RM_HSTRT = 13'b0001000000000,
    S_RM_HASH  = 13'b0010000000000,
    S_NX_SCAN  = 13'b0100000000000,
    S_NX_READ  = 13'b1000000000000
  } state_t;

endpackage

// ===== sv/lph_hash.sv =====
// ----------------------------------------------------------------------------
// lph_hash
// Byte-serial djb2 hash unit; keeps only the low index bits of the hash.
// ----------------------------------------------------------------------------
module lph_hash #(
  parameter int unsigned KEY_BYTES = 8,
  parameter int unsigned IDX_W     = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [8*KEY_BYTES-1:0] key,
  output logic                   done,
  output logic [IDX_W-1:0]       idx
);
  import lph_pkg::*;

  localparam int unsigned CNT_W = $clog2(KEY_BYTES + 1);

  logic [8*KEY_BYTES-1:0] key_sh;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       h;

  // One key byte per cycle: h = h * 33 + byte, kept to the low IDX_W bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(KEY_BYTES);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (cnt != '0) cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h      <= HASH_START[IDX_W-1:0];
      key_sh <= key;
    end else if (cnt != '0) begin
      h      <= (h << HASH_SHIFT) + h + IDX_W'(key_sh[7:0]);
      key_sh <= key_sh >> 8;
    end
  end

  assign idx = h;

endmodule

// ===== sv/lph_mem.sv =====
// ----------------------------------------------------------------------------
// lph_mem
// Key and value store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module lph_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8,
  parameter int unsigned KW    = 64,
  parameter int unsigned VW    = 32
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [KW-1:0]    wr_key,
  input  logic [VW-1:0]    wr_val,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [KW-1:0]    rd_key,
  output logic [VW-1:0]    rd_val
);
  import lph_pkg::*;

  logic [KW-1:0] keys [DEPTH];
  logic [VW-1:0] vals [DEPTH];

  // Write and read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr] <= wr_key;
      vals[wr_addr] <= wr_val;
    end
    rd_key <= keys[rd_addr];
    rd_val <= vals[rd_addr];
  end

endmodule

// ===== sv/linear_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing key/value table with linear probing and a djb2 home slot.
// ----------------------------------------------------------------------------
// Usage: one command transaction enters on the s_ group (tuser holds the
// command, tdata the key, value and slot) and exactly one result transaction
// leaves on the m_ group (tuser holds the status). Commands are insert,
// lookup, remove at a slot with backward-shift deletion, and next occupied
// slot at or after an index.
// Insert and lookup hash the key, then probe one slot at a time from the home
// slot; next occupied scans slot by slot; remove rehashes each entry of the
// probe run that follows the removed slot. The byte-serial hash unit and the
// single read port of the key/value memory set the command timing.
// One command is in flight at a time; s_tready is high only when the block
// is idle and the output register is empty.
// Reset clears all valid bits and the entry count at once; no clearing pass.
// When the receiver stalls, the result holds in the output register and no
// new command is taken until it is accepted.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned KEY_BYTES  = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // key [63:0], value [95:64], slot [103:96]
  input  logic [lph_pkg::IN_W-1:0]  s_tdata,
  // cmd [1:0]
  input  logic [lph_pkg::CMD_W-1:0] s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // slot_out [7:0], key_out [71:8], value_out [103:72], entry_total [112:104]
  output logic [lph_pkg::OUT_W-1:0]    m_tdata,
  // status [1:0]
  output logic [lph_pkg::STATUS_W-1:0] m_tuser
);
  import lph_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KW    = 8 * KEY_BYTES;
  localparam int unsigned VW    = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

  state_t state;

  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    count;
  logic [1:0]          cmd;
  logic [KW-1:0]       key;
  logic [VW-1:0]       val;
  logic [SLOT_W-1:0]   slot;
  logic [IDX_W-1:0]    pos;
  logic [IDX_W-1:0]    n;
  logic [IDX_W-1:0]    hole;
  logic [KW-1:0]       rm_key;
  logic [VW-1:0]       rm_val;
  logic [KW-1:0]       mv_key;
  logic [VW-1:0]       mv_val;

  logic             hash_start;
  logic [KW-1:0]    hash_key;
  logic             hash_done;
  logic [IDX_W-1:0] hash_idx;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KW-1:0]    wr_key;
  logic [VW-1:0]    wr_val;
  logic [KW-1:0]    rd_key;
  logic [VW-1:0]    rd_val;

  logic             accept;
  logic [KW-1:0]    in_key;
  logic [VW-1:0]    in_val;
  logic [SLOT_W-1:0] in_slot;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;
  logic [IDX_W-1:0] pos_inc;
  logic             stays;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign in_key   = s_tdata[KW-1:0];
  assign in_val   = s_tdata[64 +: VW];
  assign in_slot  = s_tdata[96 +: SLOT_W];
  assign in_idx   = IDX_W'(in_slot);
  assign in_range = (32'(in_slot) < CAPACITY);
  assign pos_inc  = pos + IDX_W'(1);

  // An entry whose home lies in the cyclic interval (hole, pos] stays put.
  always_comb begin
    if (hole <= pos) stays = (hole < hash_idx) && (hash_idx <= pos);
    else             stays = (hash_idx > hole) || (hash_idx <= pos);
  end

  // Hash unit input: the command key, or the key of an entry being moved.
  assign hash_start = (accept && (s_tuser == CMD_INSERT || s_tuser == CMD_LOOKUP))
                      || (state == S_RM_HSTRT);
  assign hash_key   = (state == S_RM_HSTRT) ? rd_key : in_key;

  // Memory writes: an insert into a free slot, or a backward shift.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_key  = key;
    wr_val  = val;
    if (state == S_INS && !valid[pos]) begin
      wr_en = 1'b1;
    end else if (state == S_RM_HASH && hash_done && !stays) begin
      wr_en   = 1'b1;
      wr_addr = hole;
      wr_key  = mv_key;
      wr_val  = mv_val;
    end
  end

  lph_hash #(.KEY_BYTES(KEY_BYTES), .IDX_W(IDX_W)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .idx   (hash_idx)
  );

  lph_mem #(.DEPTH(CAPACITY), .IDX_W(IDX_W), .KW(KW), .VW(VW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_val  (wr_val),
    .rd_addr (pos),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  // Command sequencer, valid map, entry count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd  <= s_tuser;
            key  <= in_key;
            val  <= in_val;
            slot <= in_slot;
            pos  <= in_idx;
            hole <= in_idx;
            n    <= '0;
            unique case (s_tuser) inside
              CMD_INSERT, CMD_LOOKUP: state <= S_HASH;
              CMD_REMOVE: begin
                if (in_range && valid[in_idx]) begin
                  state <= S_RM_LOAD;
                end else begin
                  m_tvalid <= 1'b1;
                  m_tuser  <= ST_NONE;
                  m_tdata  <= {OUT_W'(0)} | (OUT_W'(TOTAL_W'(count)) << 104);
                end
              end
              default: begin
                if (in_range) begin
                  state <= S_NX_SCAN;
                end else begin
                  m_tvalid <= 1'b1;
                  m_tuser  <= ST_NONE;
                  m_tdata  <= OUT_W'(TOTAL_W'(count)) << 104;
                end
              end
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            pos   <= hash_idx;
            state <= (cmd == CMD_INSERT) ? S_INS : S_LK_PROBE;
          end
        end
        S_INS: begin
          if (!valid[pos]) begin
            valid[pos] <= 1'b1;
            count      <= count + CNT_W'(1);
            m_tvalid   <= 1'b1;
            m_tuser    <= ST_OK;
            m_tdata    <= {7'd0, TOTAL_W'(count + CNT_W'(1)), VAL_W'(val), KEY_W'(key),
                           SLOT_W'(pos)};
            state      <= S_IDLE;
          end else if (n == LAST) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ST_FULL;
            m_tdata  <= OUT_W'(TOTAL_W'(count)) << 104;
            state    <= S_IDLE;
          end else begin
            pos <= pos_inc;
            n   <= n + IDX_W'(1);
          end
        end
        S_LK_PROBE: begin
          if (!valid[pos]) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ST_NONE;
            m_tdata  <= OUT_W'(TOTAL_W'(count)) << 104;
            state    <= S_IDLE;
          end else begin
            state <= S_LK_CMP;
          end
        end
        S_LK_CMP: begin
          if (rd_key == key) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ST_OK;
            m_tdata  <= {7'd0, TOTAL_W'(count), VAL_W'(rd_val), KEY_W'(rd_key),
                         SLOT_W'(pos)};
            state    <= S_IDLE;
          end else if (n == LAST) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ST_NONE;
            m_tdata  <= OUT_W'(TOTAL_W'(count)) << 104;
            state    <= S_IDLE;
          end else begin
            pos   <= pos_inc;
            n     <= n + IDX_W'(1);
            state <= S_LK_PROBE;
          end
        end
        S_RM_LOAD: state <= S_RM_SAVE;
        S_RM_SAVE: begin
          rm_key <= rd_key;
          rm_val <= rd_val;
          state  <= S_RM_STEP;
        end
        S_RM_STEP: begin
          if (!valid[pos_inc] || pos_inc == hole) begin
            valid[hole] <= 1'b0;
            count       <= count - CNT_W'(1);
            m_tvalid    <= 1'b1;
            m_tuser     <= ST_OK;
            m_tdata     <= {7'd0, TOTAL_W'(count - CNT_W'(1)), VAL_W'(rm_val),
                            KEY_W'(rm_key), slot};
            state       <= S_IDLE;
          end else begin
            pos   <= pos_inc;
            state <= S_RM_FETCH;
          end
        end
        S_RM_FETCH: state <= S_RM_HSTRT;
        S_RM_HSTRT: begin
          mv_key <= rd_key;
          mv_val <= rd_val;
          state  <= S_RM_HASH;
        end
        S_RM_HASH: begin
          if (hash_done) begin
            if (!stays) hole <= pos;
            state <= S_RM_STEP;
          end
        end
        S_NX_SCAN: begin
          if (valid[pos]) begin
            state <= S_NX_READ;
          end else if (pos == LAST) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ST_NONE;
            m_tdata  <= OUT_W'(TOTAL_W'(count)) << 104;
            state    <= S_IDLE;
          end else begin
            pos <= pos_inc;
          end
        end
        S_NX_READ: begin
          m_tvalid <= 1'b1;
          m_tuser  <= ST_OK;
          m_tdata  <= {7'd0, TOTAL_W'(count), VAL_W'(rd_val), KEY_W'(rd_key),
                       SLOT_W'(pos)};
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A command is taken only with the output register empty.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready while a result is pending");

  // The entry count never exceeds the table size.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY) else $error("entry count overflow");

  // A table-full result is only given when every slot is occupied.
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> (32'(count) == CAPACITY))
    else $error("full status with free slots");

  // The block is not ready in the cycle after it takes a command.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready) else $error("ready right after a command");

endmodule
